### rtl/core/pfa_pkg.sv
// Package of shared types and constants for the prime field arithmetic unit.
`default_nettype none

package pfa_pkg;

  // Operand and modulus width.
  localparam int W  = 31;
  // Width of a bit counter that indexes one operand bit.
  localparam int CW = $clog2(W);

  localparam logic [W-1:0] ONE = W'(1);

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } pfa_func_t;

  // Operations of the shared modular unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } pfa_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RED_A,
    ST_RED_B,
    ST_INV_SQ,
    ST_INV_MUL,
    ST_LAST
  } pfa_state_t;

  // Request from the sequencer to the modular unit.
  typedef struct packed {
    logic            go;
    pfa_op_t         op;
    logic [W-1:0]    x;
    logic [W-1:0]    y;
  } pfa_req_t;

  // Response from the modular unit.
  typedef struct packed {
    logic            done;
    logic [W-1:0]    res;
  } pfa_rsp_t;

endpackage

`default_nettype wire

### rtl/core/pfa_modunit.sv
// Shared modular unit: bit-serial multiply modulo p, and single-step add and subtract.
`default_nettype none

module pfa_modunit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [pfa_pkg::W-1:0] modulus,
  input  wire pfa_pkg::pfa_req_t    req,
  output pfa_pkg::pfa_rsp_t         rsp
);

  localparam int W = pfa_pkg::W;

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  pfa_pkg::pfa_op_t    op_r, op_nxt;
  logic [W-1:0]        x_r, x_nxt;
  logic [W-1:0]        y_r, y_nxt;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [pfa_pkg::CW-1:0] cnt_r, cnt_nxt;

  logic [W+1:0]        t;
  logic [W+2:0]        d1;
  logic [W+2:0]        d2;
  logic [W-1:0]        red;

  // Value to be reduced; it always stays below 3p, so at most 2p is taken off.
  always_comb begin
    case (op_r)
      pfa_pkg::OP_ADD: t = {2'b00, x_r} + {2'b00, y_r};
      pfa_pkg::OP_SUB: t = {2'b00, x_r} + {2'b00, modulus} - {2'b00, y_r};
      default:         t = {1'b0, acc_r, 1'b0} + (y_r[W-1] ? {2'b00, x_r} : '0);
    endcase
    d1 = {1'b0, t} - {3'b000, modulus};
    d2 = {1'b0, t} - {2'b00, modulus, 1'b0};
    if (!d2[W+2]) begin
      red = d2[W-1:0];
    end else if (!d1[W+2]) begin
      red = d1[W-1:0];
    end else begin
      red = t[W-1:0];
    end
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    if (req.go) begin
      run_nxt = 1'b1;
      op_nxt  = req.op;
      x_nxt   = req.x;
      y_nxt   = req.y;
      acc_nxt = '0;
      cnt_nxt = pfa_pkg::CW'(W - 1);
    end else if (run_r) begin
      acc_nxt = red;
      y_nxt   = {y_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (op_r != pfa_pkg::OP_MUL || cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

  a_go_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> !run_r)
    else $error("modular unit started while still running");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r))
    else $error("modular unit finished without running");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < modulus))
    else $error("modular unit result not below the modulus");

endmodule

`default_nettype wire

### rtl/core/pfa_ctrl.sv
// Sequencer: operand reduction, operation dispatch and Fermat inversion.
`default_nettype none

module pfa_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [pfa_pkg::W-1:0] modulus,
  input  wire logic                  start,
  input  wire logic [1:0]            func,
  input  wire logic [pfa_pkg::W-1:0] operand_a,
  input  wire logic [pfa_pkg::W-1:0] operand_b,
  output logic                       busy,
  output pfa_pkg::pfa_req_t          req,
  input  wire pfa_pkg::pfa_rsp_t     rsp,
  output logic                       strobe,
  output logic [pfa_pkg::W-1:0]      field_result,
  output logic                       div_by_zero,
  output logic                       operands_equal,
  output logic                       a_less_than_b
);

  localparam int W = pfa_pkg::W;

  pfa_pkg::pfa_state_t    state_r, state_nxt;
  pfa_pkg::pfa_func_t     func_r, func_nxt;
  logic [W-1:0]           a_r, a_nxt;
  logic [W-1:0]           b_r, b_nxt;
  logic [W-1:0]           exp_r, exp_nxt;
  logic [pfa_pkg::CW-1:0] cnt_r, cnt_nxt;
  logic                   strobe_r, strobe_nxt;
  logic [W-1:0]           res_r, res_nxt;
  logic                   err_r, err_nxt;
  logic                   eq_r, eq_nxt;
  logic                   lt_r, lt_nxt;
  logic                   adv;

  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    exp_nxt    = exp_r;
    cnt_nxt    = cnt_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;
    err_nxt    = err_r;
    eq_nxt     = eq_r;
    lt_nxt     = lt_r;
    adv        = 1'b0;
    req.go     = 1'b0;
    req.op     = pfa_pkg::OP_MUL;
    req.x      = '0;
    req.y      = '0;

    case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (start) begin
          func_nxt  = pfa_pkg::pfa_func_t'(func);
          a_nxt     = operand_a;
          b_nxt     = operand_b;
          state_nxt = pfa_pkg::ST_LOAD;
        end
      end
      pfa_pkg::ST_LOAD: begin
        if (modulus < W'(2)) begin
          // Degenerate field: everything reduces to zero.
          res_nxt    = '0;
          err_nxt    = (func_r == pfa_pkg::FN_DIV);
          eq_nxt     = 1'b1;
          lt_nxt     = 1'b0;
          strobe_nxt = 1'b1;
          state_nxt  = pfa_pkg::ST_IDLE;
        end else begin
          req.go    = 1'b1;
          req.x     = pfa_pkg::ONE;
          req.y     = a_r;
          state_nxt = pfa_pkg::ST_RED_A;
        end
      end
      pfa_pkg::ST_RED_A: begin
        if (rsp.done) begin
          a_nxt     = rsp.res;
          req.go    = 1'b1;
          req.x     = pfa_pkg::ONE;
          req.y     = b_r;
          state_nxt = pfa_pkg::ST_RED_B;
        end
      end
      pfa_pkg::ST_RED_B: begin
        if (rsp.done) begin
          b_nxt   = rsp.res;
          eq_nxt  = (a_r == rsp.res);
          lt_nxt  = (a_r < rsp.res);
          err_nxt = 1'b0;
          req.x   = a_r;
          req.y   = rsp.res;
          case (func_r)
            pfa_pkg::FN_ADD: begin
              req.go    = 1'b1;
              req.op    = pfa_pkg::OP_ADD;
              state_nxt = pfa_pkg::ST_LAST;
            end
            pfa_pkg::FN_SUB: begin
              req.go    = 1'b1;
              req.op    = pfa_pkg::OP_SUB;
              state_nxt = pfa_pkg::ST_LAST;
            end
            pfa_pkg::FN_MUL: begin
              req.go    = 1'b1;
              state_nxt = pfa_pkg::ST_LAST;
            end
            default: begin
              if (rsp.res == '0) begin
                res_nxt    = '0;
                err_nxt    = 1'b1;
                strobe_nxt = 1'b1;
                state_nxt  = pfa_pkg::ST_IDLE;
              end else begin
                // Exponent p-2 scanned from its top bit, accumulator starts at one.
                exp_nxt   = modulus - W'(2);
                cnt_nxt   = pfa_pkg::CW'(W - 1);
                req.go    = 1'b1;
                req.x     = pfa_pkg::ONE;
                req.y     = pfa_pkg::ONE;
                state_nxt = pfa_pkg::ST_INV_SQ;
              end
            end
          endcase
        end
      end
      pfa_pkg::ST_INV_SQ: begin
        if (rsp.done) begin
          if (exp_r[W-1]) begin
            req.go    = 1'b1;
            req.x     = rsp.res;
            req.y     = b_r;
            state_nxt = pfa_pkg::ST_INV_MUL;
          end else begin
            adv = 1'b1;
          end
        end
      end
      pfa_pkg::ST_INV_MUL: begin
        adv = rsp.done;
      end
      pfa_pkg::ST_LAST: begin
        if (rsp.done) begin
          res_nxt    = rsp.res;
          strobe_nxt = 1'b1;
          state_nxt  = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfa_pkg::ST_IDLE;
      end
    endcase

    // Move to the next exponent bit, or finish with a times the inverse.
    if (adv) begin
      req.go = 1'b1;
      req.op = pfa_pkg::OP_MUL;
      if (cnt_r == '0) begin
        req.x     = a_r;
        req.y     = rsp.res;
        state_nxt = pfa_pkg::ST_LAST;
      end else begin
        req.x     = rsp.res;
        req.y     = rsp.res;
        cnt_nxt   = cnt_r - 1'b1;
        exp_nxt   = {exp_r[W-2:0], 1'b0};
        state_nxt = pfa_pkg::ST_INV_SQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pfa_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    func_r <= func_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    err_r  <= err_nxt;
    eq_r   <= eq_nxt;
    lt_r   <= lt_nxt;
  end

  assign busy           = (state_r != pfa_pkg::ST_IDLE);
  assign strobe         = strobe_r;
  assign field_result   = res_r;
  assign div_by_zero    = err_r;
  assign operands_equal = eq_r;
  assign a_less_than_b  = lt_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |=> !strobe_r)
    else $error("result strobe held for more than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && err_r) |-> (res_r == '0 && func_r == pfa_pkg::FN_DIV))
    else $error("error raised with nonzero result or outside divide");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !(eq_r && lt_r))
    else $error("equal and less-than flags both set");

endmodule

`default_nettype wire

### rtl/core/prime_field_alu.sv
// Top level of the prime field arithmetic unit: modulus register, sequencer and modular unit.
`default_nettype none

// Arithmetic over GF(p) for a prime p of up to 31 bits held in the modulus register
// (reset value 2^31-1, written through cfg_we/cfg_wdata; the user must write it only
// while the unit is idle, which the block itself does not enforce). An item is taken
// when start is high and busy is low; busy then stays high until the result is out,
// and the result appears for exactly one cycle with out_strobe high. The receiver
// cannot stall, so it must capture the result in that cycle. With a modulus of two or
// more, every item first reduces both operands modulo p on the shared bit-serial
// modular unit, which retires one multiplier bit a cycle. A divide raises the divisor
// to the power p-2 by square-and-multiply, 31 squarings and one multiply for each set
// bit of p-2 (thirty for p = 2^31-1), then multiplies by the left operand. A zero
// divisor returns zero with out_div_by_zero set straight after the reductions. With a
// modulus of zero or one every operand counts as zero and the item completes without
// using the modular unit.

module prime_field_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [30:0] in_operand_a,
  input  wire logic [30:0] in_operand_b,
  output logic             out_strobe,
  output logic [30:0]      out_field_result,
  output logic             out_div_by_zero,
  output logic             out_operands_equal,
  output logic             out_a_less_than_b
);

  logic [pfa_pkg::W-1:0] modulus_r;
  pfa_pkg::pfa_req_t     req;
  pfa_pkg::pfa_rsp_t     rsp;

  // The user writes the modulus register only while no item is in flight (not enforced).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= {pfa_pkg::W{1'b1}};
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata[pfa_pkg::W-1:0];
    end
  end

  pfa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .modulus        (modulus_r),
    .start          (start),
    .func           (in_func),
    .operand_a      (in_operand_a[pfa_pkg::W-1:0]),
    .operand_b      (in_operand_b[pfa_pkg::W-1:0]),
    .busy           (busy),
    .req            (req),
    .rsp            (rsp),
    .strobe         (out_strobe),
    .field_result   (out_field_result),
    .div_by_zero    (out_div_by_zero),
    .operands_equal (out_operands_equal),
    .a_less_than_b  (out_a_less_than_b)
  );

  pfa_modunit u_modunit (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .req     (req),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
